@@ rtl/vtcb_pkg.sv @@
// Package for the virtual timer channel bank.
// Holds the word types, request codes and sizing constants used by all rtl files.
// Depends on nothing.
`timescale 1ns / 1ps

package vtcb_pkg;

	// Bank sizing and rate window for set frequency.
	localparam int NUM_CHANNELS = 5;
	localparam int MAX_RATE     = 15;
	localparam int MIN_RATE     = 6;
	localparam int CHAN_W       = 3;
	localparam int LOG2_W       = 5;
	localparam int RATE_SPAN    = MAX_RATE - MIN_RATE + 1;

	// Request codes.
	localparam logic [2:0] FUNC_TICK  = 3'd0;
	localparam logic [2:0] FUNC_OPEN  = 3'd1;
	localparam logic [2:0] FUNC_CLOSE = 3'd2;
	localparam logic [2:0] FUNC_FREQ  = 3'd3;
	localparam logic [2:0] FUNC_ARM   = 3'd4;

	// Configuration register indexes and reset values.
	localparam logic REG_REFRESH_PERIOD = 1'b0;
	localparam logic REG_CLOCK_PERIOD   = 1'b1;
	localparam logic [7:0] REFRESH_RESET = 8'd40;
	localparam logic [9:0] CLOCK_RESET   = 10'd500;

	// Required length of a set-frequency value.
	localparam logic [7:0] FREQ_BYTES = 8'd4;

	typedef struct packed {
		logic [2:0]         func;
		logic [2:0]         slot;
		logic               slot_valid;
		logic signed [31:0] freq_value;
		logic [7:0]         byte_count;
		logic               value_present;
	} in_word_t;

	typedef struct packed {
		logic       status;
		logic [2:0] granted_slot;
		logic [4:0] done_mask;
		logic       clock_event;
		logic       refresh_event;
	} out_word_t;

	// Channel bank answer for one request.
	typedef struct packed {
		logic                    status;
		logic [2:0]              granted_slot;
		logic [NUM_CHANNELS-1:0] done_mask;
	} chan_resp_t;

	// Periodic counter events for one tick.
	typedef struct packed {
		logic clock_event;
		logic refresh_event;
	} tick_evt_t;

endpackage

@@ rtl/vtcb_chan_bank.sv @@
// Channel state of the virtual timer bank: free flags, periods and down-counters.
// Executes one request word per fire and returns status, granted channel and done mask.
// Depends on vtcb_pkg.
`timescale 1ns / 1ps

module vtcb_chan_bank (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fire,
	input  vtcb_pkg::in_word_t   word,
	output vtcb_pkg::chan_resp_t resp
);
	import vtcb_pkg::*;

	logic [NUM_CHANNELS-1:0] free_q;
	logic [7:0]              period_q [NUM_CHANNELS];
	logic [7:0]              count_q  [NUM_CHANNELS];

	logic [NUM_CHANNELS-1:0] free_d;
	logic [7:0]              period_d [NUM_CHANNELS];
	logic [7:0]              count_d  [NUM_CHANNELS];

	logic              slot_in_range;
	logic              held_ok;
	logic [CHAN_W-1:0] idx;
	logic              found;
	logic [CHAN_W-1:0] first_free;
	logic [31:0]       freq;
	logic              pow2;
	logic [LOG2_W-1:0] pw;
	logic              freq_ok;
	logic [7:0]        new_period;

	assign slot_in_range = word.slot < 3'(NUM_CHANNELS);
	assign held_ok       = word.slot_valid && slot_in_range;
	assign idx           = word.slot[CHAN_W-1:0];

	// Lowest free channel for an open without a held channel.
	always_comb begin
		found      = 1'b0;
		first_free = '0;
		for (int i = 0; i < NUM_CHANNELS; i++) begin
			if (free_q[i] && !found) begin
				found      = 1'b1;
				first_free = CHAN_W'(i);
			end
		end
	end

	// Frequency checks: power of two, log2 taken from the single set bit.
	always_comb begin
		freq = word.freq_value;
		pow2 = (freq & (freq - 32'd1)) == 32'd0;
		pw   = '0;
		for (int i = 0; i < 31; i++) begin
			if (freq[i]) begin
				pw = pw | LOG2_W'(i);
			end
		end
		freq_ok = (word.byte_count == FREQ_BYTES) && word.value_present && pow2 &&
			!freq[31] && (pw != '0) && (pw < LOG2_W'(RATE_SPAN)) && held_ok;
		new_period = 8'(9'd256 >> pw);
	end

	// Request decode and next state.
	always_comb begin
		free_d   = free_q;
		period_d = period_q;
		count_d  = count_q;
		resp     = '0;
		unique case (word.func)
			FUNC_TICK: begin
				for (int i = 0; i < NUM_CHANNELS; i++) begin
					count_d[i] = (count_q[i] != 8'd0) ? count_q[i] - 8'd1 : 8'd0;
					resp.done_mask[i] = (count_d[i] == 8'd0);
				end
			end
			FUNC_OPEN: begin
				if (word.slot_valid) begin
					resp.status       = !slot_in_range;
					resp.granted_slot = slot_in_range ? word.slot : 3'd0;
				end else begin
					resp.status       = !found;
					resp.granted_slot = found ? 3'(first_free) : 3'd0;
				end
				if (!resp.status) begin
					free_d[resp.granted_slot[CHAN_W-1:0]]   = 1'b0;
					period_d[resp.granted_slot[CHAN_W-1:0]] = 8'd1;
				end
			end
			FUNC_CLOSE: begin
				if (held_ok) begin
					free_d[idx] = 1'b1;
				end
			end
			FUNC_FREQ: begin
				resp.status = !freq_ok;
				if (freq_ok) begin
					period_d[idx] = new_period;
				end
			end
			FUNC_ARM: begin
				resp.status = !held_ok;
				if (held_ok) begin
					count_d[idx] = period_q[idx];
				end
			end
			default: begin
				resp.status = 1'b1;
			end
		endcase
	end

	// Channel state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_q <= '1;
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				period_q[i] <= 8'd0;
				count_q[i]  <= 8'd0;
			end
		end else if (fire) begin
			free_q   <= free_d;
			period_q <= period_d;
			count_q  <= count_d;
		end
	end

	// A granted channel is busy afterwards.
	a_open_marks_busy: assert property (@(posedge clk) disable iff (!arst_n)
		fire && word.func == FUNC_OPEN && !resp.status
		|=> !free_q[$past(resp.granted_slot[CHAN_W-1:0])])
		else $error("open left granted channel free");

	// Only a tick reports done channels.
	a_mask_only_on_tick: assert property (@(posedge clk) disable iff (!arst_n)
		fire && word.func != FUNC_TICK |-> resp.done_mask == '0)
		else $error("done mask outside tick");

	// A successful arm loads the counter from the period.
	a_arm_loads: assert property (@(posedge clk) disable iff (!arst_n)
		fire && word.func == FUNC_ARM && !resp.status
		|=> count_q[$past(idx)] == period_q[$past(idx)])
		else $error("arm did not load counter");

endmodule

@@ rtl/vtcb_periodic.sv @@
// Fixed periodic counters for the refresh and time-of-day events.
// Counts down on every tick, fires at one or zero and reloads from its period register.
// Depends on vtcb_pkg.
`timescale 1ns / 1ps

module vtcb_periodic (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                tick,
	input  logic [7:0]          refresh_period,
	input  logic [9:0]          clock_period,
	output vtcb_pkg::tick_evt_t evt
);
	import vtcb_pkg::*;

	logic [7:0] refresh_count_q;
	logic [9:0] clock_count_q;

	// An event is due when the counter has run down to one or zero.
	assign evt.clock_event   = clock_count_q <= 10'd1;
	assign evt.refresh_event = refresh_count_q <= 8'd1;

	// Reload on an event, otherwise count down.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			refresh_count_q <= REFRESH_RESET;
			clock_count_q   <= CLOCK_RESET;
		end else if (tick) begin
			clock_count_q   <= evt.clock_event ? clock_period : clock_count_q - 10'd1;
			refresh_count_q <= evt.refresh_event ? refresh_period
				: refresh_count_q - 8'd1;
		end
	end

	a_clock_reload: assert property (@(posedge clk) disable iff (!arst_n)
		tick && evt.clock_event |=> clock_count_q == $past(clock_period))
		else $error("clock counter not reloaded");

	a_refresh_count: assert property (@(posedge clk) disable iff (!arst_n)
		tick && !evt.refresh_event |=> refresh_count_q == $past(refresh_count_q) - 8'd1)
		else $error("refresh counter did not count down");

	a_idle_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!tick |=> $stable(clock_count_q) && $stable(refresh_count_q))
		else $error("periodic counters moved without tick");

endmodule

@@ rtl/virtual_timer_channel_bank.sv @@
// Top level of the virtual timer channel bank.
// Holds the input and result registers, the configuration port and the two units.
// Depends on vtcb_pkg, vtcb_chan_bank and vtcb_periodic.
`timescale 1ns / 1ps

// The bank takes one request word per clock unless stalled and returns one result word
// for each. The word is captured in an input register at acceptance. The channel bank
// and the periodic counters act on it when it moves on, and its result is loaded into
// an output register at that edge. The result is presented from the output register and
// held there until taken. Throughput is one word per cycle and falls only while the
// output is stalled. The refresh and clock periods are written over the configuration
// port at byte addresses 0 and 4 and should be changed only while the bank is idle.
module virtual_timer_channel_bank (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  vtcb_pkg::in_word_t  in_word,
	output logic                out_valid,
	input  logic                out_stall,
	output vtcb_pkg::out_word_t out_word,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);
	import vtcb_pkg::*;

	logic       valid_s1;
	in_word_t   word_s1;
	logic       out_valid_q;
	out_word_t  out_word_q;
	logic [7:0] refresh_period_q;
	logic [9:0] clock_period_q;
	logic       advance;
	logic       accept;
	logic       tick;
	chan_resp_t resp;
	tick_evt_t  evt;

	// Configuration port: always ready, written on the access cycle.
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			refresh_period_q <= REFRESH_RESET;
			clock_period_q   <= CLOCK_RESET;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				REG_REFRESH_PERIOD: refresh_period_q <= pwdata[7:0];
				REG_CLOCK_PERIOD:   clock_period_q   <= pwdata[9:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_REFRESH_PERIOD: prdata = {24'd0, refresh_period_q};
			REG_CLOCK_PERIOD:   prdata = {22'd0, clock_period_q};
			default:            prdata = 32'd0;
		endcase
	end

	// Handshake: the input register moves on whenever the result register can take a word.
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;
	assign tick     = advance && (word_s1.func == FUNC_TICK);

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			word_s1 <= in_word;
		end
	end

	vtcb_chan_bank u_chan_bank (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.word   (word_s1),
		.resp   (resp)
	);

	vtcb_periodic u_periodic (
		.clk            (clk),
		.arst_n         (arst_n),
		.tick           (tick),
		.refresh_period (refresh_period_q),
		.clock_period   (clock_period_q),
		.evt            (evt)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_word_q.status        <= resp.status;
			out_word_q.granted_slot  <= resp.granted_slot;
			out_word_q.done_mask     <= resp.done_mask;
			out_word_q.clock_event   <= tick && evt.clock_event;
			out_word_q.refresh_event <= tick && evt.refresh_event;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

endmodule
